### hdl/lru_key_value_cache_assert.svh
// Assertion macros shared by the LRU key/value cache RTL.
// Self-contained; included by the top level of the cache.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lkv_pkg.sv
// Package of the LRU key/value cache: widths, defaults, codes and state type.
// No dependencies; used by the interfaces, the cell and the top level.
package lkv_pkg;

    localparam int DATA_W        = 32;
    localparam int KEY_PORT_W    = 32;
    localparam int CFG_W         = 5;
    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_KEY_WIDTH = 32;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } t_state;

endpackage

### hdl/lkv_if.sv
// Valid/ready channel interfaces of the LRU key/value cache.
// Depends on lkv_pkg for the field widths.
interface lkv_req_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic [lkv_pkg::KEY_PORT_W-1:0]      key;
    logic signed [lkv_pkg::DATA_W-1:0]   value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lkv_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                found;
    logic signed [lkv_pkg::DATA_W-1:0]   read_value;
    logic                                evicted;
    logic [lkv_pkg::KEY_PORT_W-1:0]      evicted_key;

    modport source (output valid, output found, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input found, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

interface lkv_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lkv_pkg::CFG_W-1:0]           data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/lkv_cell.sv
// One cell of the recency chain: holds one entry and compares it to the key.
// Depends on lkv_pkg for the value width and the default key width.
module lkv_cell #(
    parameter int KW = lkv_pkg::DEF_KEY_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_shift,
    input  logic                              i_prev_valid,
    input  logic [KW-1:0]                     i_prev_key,
    input  logic [lkv_pkg::DATA_W-1:0]        i_prev_value,
    input  logic [KW-1:0]                     i_cmp_key,
    output logic                              o_valid,
    output logic [KW-1:0]                     o_key,
    output logic [lkv_pkg::DATA_W-1:0]        o_value,
    output logic                              o_match
);

    logic                          r_valid;
    logic [KW-1:0]                 r_key;
    logic [lkv_pkg::DATA_W-1:0]    r_value;
    logic                          r_match;
    logic                          n_match;

    assign n_match = r_valid && (r_key == i_cmp_key);

    // Control state: valid and match flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
            if (i_shift) begin
                r_valid <= i_prev_valid;
            end
        end
    end

    // Payload: taken from the neighbor when the chain shifts.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_match = r_match;

endmodule

### hdl/lru_key_value_cache.sv
// Top level of the fully associative LRU key/value cache built as a chain of cells.
// Depends on lkv_pkg, the interfaces in lkv_if.sv, lkv_cell and the assertion header.
//
//   Channel   Dir  Handshake      Payload
//   i_req     in   valid/ready    func, key, value
//   o_rsp     out  valid/ready    found, read_value, evicted, evicted_key
//   i_cfg     in   valid/ready    data (capacity register)
//
// An item passes a compare state, in which every cell compares its key, then a shift state.
// A new request is taken while idle or in the shift state, so one item ends before the next starts.
// Reset (synchronous, active low) empties every cell and sets the capacity register to 16.
// A waiting response holds the block in its shift cycle until o_rsp transfers.
// Configuration writes are always taken, one per cycle.
module lru_key_value_cache #(
    parameter int CAPACITY  = lkv_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH = lkv_pkg::DEF_KEY_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lkv_req_if.sink    i_req,
    lkv_rsp_if.source  o_rsp,
    lkv_cfg_if.sink    i_cfg
);

    `include "lru_key_value_cache_assert.svh"

    // Keys are compared on the bits that both the port and KEY_WIDTH carry.
    localparam int KW    = (KEY_WIDTH < lkv_pkg::KEY_PORT_W) ? KEY_WIDTH : lkv_pkg::KEY_PORT_W;
    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (OCC_W > lkv_pkg::CFG_W) ? OCC_W : lkv_pkg::CFG_W;

    // Cell i of the chain holds the entry of recency rank i; the valid cells are
    // always a contiguous run starting at cell 0, so occupancy is its length.
    lkv_pkg::t_state                 r_state, n_state;
    logic [lkv_pkg::CFG_W-1:0]       r_capacity;
    logic [OCC_W-1:0]                r_occ, n_occ;
    logic                            r_func;
    logic [KW-1:0]                   r_key;
    logic [lkv_pkg::DATA_W-1:0]      r_value;

    logic                            r_out_valid;
    logic                            r_found;
    logic [lkv_pkg::DATA_W-1:0]      r_read_value;
    logic                            r_evicted;
    logic [lkv_pkg::KEY_PORT_W-1:0]  r_evicted_key;

    logic                            w_req_ready;
    logic                            w_take;
    logic                            w_step;
    logic                            w_out_free;

    logic [CAPACITY-1:0]             w_valid;
    logic [CAPACITY-1:0]             w_match;
    logic [CAPACITY-1:0]             w_last;
    logic [CAPACITY-1:0]             w_hit_mask;
    logic [CAPACITY-1:0]             w_ins_mask;
    logic [CAPACITY-1:0]             w_shift;
    logic [KW-1:0]                   w_key   [CAPACITY];
    logic [lkv_pkg::DATA_W-1:0]      w_value [CAPACITY];

    logic                            w_hit;
    logic [lkv_pkg::DATA_W-1:0]      w_hit_value;
    logic [KW-1:0]                   w_last_key;
    logic [CMP_W-1:0]                w_eff_cap;
    logic                            w_full;
    logic                            w_evict;
    logic                            w_insert;
    logic [OCC_W-1:0]                w_ins_end;
    logic [lkv_pkg::DATA_W-1:0]      w_head_value;

    // ------------------------------------------------------------------
    // Sequencer: idle, compare, shift. The response register is free when
    // it is empty or its transfer happens in this cycle.
    // ------------------------------------------------------------------
    assign w_out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lkv_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = lkv_pkg::ST_LOOKUP;
                end
            end
            lkv_pkg::ST_LOOKUP: begin
                n_state = lkv_pkg::ST_UPDATE;
            end
            lkv_pkg::ST_UPDATE: begin
                if (w_out_free) begin
                    n_state = i_req.valid ? lkv_pkg::ST_LOOKUP : lkv_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_req_ready = 1'b0;
        w_step      = 1'b0;
        unique case (r_state)
            lkv_pkg::ST_IDLE: begin
                w_req_ready = 1'b1;
            end
            lkv_pkg::ST_LOOKUP: begin
                w_req_ready = 1'b0;
            end
            lkv_pkg::ST_UPDATE: begin
                w_req_ready = w_out_free;
                w_step      = w_out_free;
            end
            default: begin
                w_req_ready = 1'b0;
            end
        endcase
    end

    assign i_req.ready = w_req_ready;
    assign w_take      = i_req.valid && w_req_ready;
    assign i_cfg.ready = 1'b1;

    // ------------------------------------------------------------------
    // Decision logic of the shift cycle.
    // ------------------------------------------------------------------

    // A capacity of zero acts as one; values above the cell count saturate.
    always_comb begin
        if (r_capacity == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_capacity) > CMP_W'(CAPACITY)) begin
            w_eff_cap = CMP_W'(CAPACITY);
        end else begin
            w_eff_cap = CMP_W'(r_capacity);
        end
    end

    // Keys are unique among valid cells, so at most one match bit is set and
    // the selections below are plain AND-OR trees.
    always_comb begin
        w_hit_value = '0;
        w_last_key  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_hit_value = w_hit_value | (w_value[i] & {lkv_pkg::DATA_W{w_match[i]}});
            w_last_key  = w_last_key | (w_key[i] & {KW{w_last[i]}});
        end
    end

    assign w_hit    = |w_match;
    assign w_full   = CMP_W'(r_occ) >= w_eff_cap;
    assign w_insert = (r_func == lkv_pkg::FUNC_PUT) && !w_hit;
    assign w_evict  = w_insert && w_full;

    // On an insert the chain shifts from cell 0 down to the first free cell,
    // or down to the least recent cell when that one is pushed out.
    assign w_ins_end = w_evict ? (r_occ - OCC_W'(1)) : r_occ;

    // A put hit carries the new value to the head; a get hit carries its own.
    assign w_head_value = (r_func == lkv_pkg::FUNC_PUT) ? r_value : w_hit_value;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_mask
            // A hit at rank h moves ranks 0 .. h-1 one place down and h to the head.
            assign w_hit_mask[g] = |(w_match >> g);
            assign w_ins_mask[g] = OCC_W'(g) <= w_ins_end;
            if (g == CAPACITY - 1) begin : g_tail
                assign w_last[g] = w_valid[g];
            end else begin : g_body
                assign w_last[g] = w_valid[g] && !w_valid[g+1];
            end
        end
    endgenerate

    always_comb begin
        w_shift = '0;
        if (w_step) begin
            if (w_hit) begin
                w_shift = w_hit_mask;
            end else if (w_insert) begin
                w_shift = w_ins_mask;
            end
        end
    end

    // ------------------------------------------------------------------
    // The chain of cells. Cell 0 takes the head entry, every other cell
    // takes its more recent neighbor.
    // ------------------------------------------------------------------
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_head
                lkv_cell #(
                    .KW (KW)
                ) u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_shift      (w_shift[g]),
                    .i_prev_valid (1'b1),
                    .i_prev_key   (r_key),
                    .i_prev_value (w_head_value),
                    .i_cmp_key    (r_key),
                    .o_valid      (w_valid[g]),
                    .o_key        (w_key[g]),
                    .o_value      (w_value[g]),
                    .o_match      (w_match[g])
                );
            end else begin : g_rest
                lkv_cell #(
                    .KW (KW)
                ) u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_shift      (w_shift[g]),
                    .i_prev_valid (w_valid[g-1]),
                    .i_prev_key   (w_key[g-1]),
                    .i_prev_value (w_value[g-1]),
                    .i_cmp_key    (r_key),
                    .o_valid      (w_valid[g]),
                    .o_key        (w_key[g]),
                    .o_value      (w_value[g]),
                    .o_match      (w_match[g])
                );
            end
        end
    endgenerate

    // Occupancy grows only on an insert that finds room.
    always_comb begin
        n_occ = r_occ;
        if (w_step && w_insert && !w_evict) begin
            n_occ = r_occ + OCC_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lkv_pkg::ST_IDLE;
            r_capacity  <= lkv_pkg::CAP_RESET;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (i_cfg.valid) begin
                r_capacity <= i_cfg.data;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and response payloads.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_func  <= i_req.func;
            r_key   <= i_req.key[KW-1:0];
            r_value <= i_req.value;
        end
        if (w_step) begin
            r_found       <= w_hit;
            r_read_value  <= (w_hit && (r_func == lkv_pkg::FUNC_GET)) ? w_hit_value : '0;
            r_evicted     <= w_evict;
            r_evicted_key <= w_evict ? lkv_pkg::KEY_PORT_W'(w_last_key) : '0;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_found;
    assign o_rsp.read_value  = r_read_value;
    assign o_rsp.evicted     = r_evicted;
    assign o_rsp.evicted_key = r_evicted_key;

    // ------------------------------------------------------------------
    // Checks on the chain and the sequencer.
    // ------------------------------------------------------------------
    `LKV_ASSERT_IMPL(a_match_unique, i_clk, i_rst_n, 1'b1, $onehot0(w_match),
        "more than one cell matches the key")
    `LKV_ASSERT_IMPL(a_valid_packed, i_clk, i_rst_n, 1'b1,
        ((w_valid + CAPACITY'(1)) & w_valid) == '0,
        "valid cells are not a contiguous run from the head")
    `LKV_ASSERT_IMPL(a_occ_count, i_clk, i_rst_n, 1'b1,
        int'(r_occ) == $countones(w_valid),
        "occupancy differs from the number of valid cells")
    `LKV_ASSERT_NEXT(a_step_result, i_clk, i_rst_n, w_step, o_rsp.valid,
        "shift cycle did not produce a response")

endmodule

### test/testbench.sv
// Self-checking testbench of the LRU key/value cache: a directed table, then random phases.
// Depends on lkv_pkg, the channel interfaces in lkv_if.sv and the lru_key_value_cache RTL.
// Responses are checked field by field against a cycle-free model of the cache state.
module testbench;

    localparam int SLOTS           = lkv_pkg::DEF_CAPACITY;
    localparam int HALF_PERIOD     = 6;
    localparam int LONG_HOLD       = 300;
    localparam int POOL_SIZE       = 32;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int NUM_PHASES      = 10;
    localparam int DRAIN_CYCLES    = 4;

    // One response as the block reports it.
    typedef struct packed {
        logic                           found;
        logic [lkv_pkg::DATA_W-1:0]     read_value;
        logic                           evicted;
        logic [lkv_pkg::KEY_PORT_W-1:0] evicted_key;
    } t_outcome;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    // A row of the directed table. A request row may carry a typed-in outcome;
    // a configuration row writes the capacity register once the cache is idle.
    typedef struct packed {
        t_row_kind                      kind;
        logic                           func;
        logic [lkv_pkg::KEY_PORT_W-1:0] key;
        logic [lkv_pkg::DATA_W-1:0]     value;
        logic [lkv_pkg::CFG_W-1:0]      capacity;
        logic                           typed;
        t_outcome                       outcome;
    } t_row;

    localparam t_outcome NO_HIT  = '{1'b0, 32'h0, 1'b0, 32'h0};
    localparam t_outcome PUT_HIT = '{1'b1, 32'h0, 1'b0, 32'h0};

    localparam int NUM_ROWS = 23;

    // The first rows start from an empty cache at the reset capacity, so their
    // outcomes are obvious. Then the capacity is lowered below the occupancy,
    // set to zero (acts as one), set above the slot count (saturates), set to
    // one and finally put back to its reset value.
    localparam t_row DIRECTED [NUM_ROWS] = '{
        '{ROW_REQ, lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, NO_HIT},
        '{ROW_REQ, lkv_pkg::FUNC_PUT, 32'h0000_0000, 32'h7FFF_FFFF, 5'd0, 1'b1, NO_HIT},
        '{ROW_REQ, lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1,
          '{1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}},
        '{ROW_REQ, lkv_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'h8000_0000, 5'd0, 1'b1, NO_HIT},
        '{ROW_REQ, lkv_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h1234_5678, 5'd0, 1'b1,
          '{1'b1, 32'h8000_0000, 1'b0, 32'h0}},
        '{ROW_REQ, lkv_pkg::FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 5'd0, 1'b1, PUT_HIT},
        '{ROW_REQ, lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
        '{ROW_REQ, lkv_pkg::FUNC_PUT, 32'h0000_0001, 32'h0000_0001, 5'd0, 1'b0, NO_HIT},
        '{ROW_REQ, lkv_pkg::FUNC_PUT, 32'h0000_0002, 32'h0000_0002, 5'd0, 1'b0, NO_HIT},
        '{ROW_CFG, lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000, 5'd2, 1'b0, NO_HIT},
        '{ROW_REQ, lkv_pkg::FUNC_PUT, 32'h0000_0003, 32'h0000_0003, 5'd0, 1'b1,
          '{1'b0, 32'h0, 1'b1, 32'hFFFF_FFFF}},
        '{ROW_REQ, lkv_pkg::FUNC_PUT, 32'h0000_0004, 32'h0000_0004, 5'd0, 1'b0, NO_HIT},
        '{ROW_REQ, lkv_pkg::FUNC_GET, 32'h0000_0001, 32'h0000_0000, 5'd0, 1'b0, NO_HIT},
        '{ROW_CFG, lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, NO_HIT},
        '{ROW_REQ, lkv_pkg::FUNC_PUT, 32'h0000_0005, 32'hDEAD_BEEF, 5'd0, 1'b0, NO_HIT},
        '{ROW_REQ, lkv_pkg::FUNC_GET, 32'h0000_0005, 32'h0000_0000, 5'd0, 1'b0, NO_HIT},
        '{ROW_CFG, lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000, 5'd31, 1'b0, NO_HIT},
        '{ROW_REQ, lkv_pkg::FUNC_PUT, 32'h0000_0006, 32'h0000_0006, 5'd0, 1'b0, NO_HIT},
        '{ROW_REQ, lkv_pkg::FUNC_PUT, 32'h0000_0007, 32'h0000_0007, 5'd0, 1'b0, NO_HIT},
        '{ROW_CFG, lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000, 5'd1, 1'b0, NO_HIT},
        '{ROW_REQ, lkv_pkg::FUNC_GET, 32'h0000_0002, 32'h0000_0000, 5'd0, 1'b0, NO_HIT},
        '{ROW_REQ, lkv_pkg::FUNC_PUT, 32'h0000_0008, 32'h0000_0008, 5'd0, 1'b0, NO_HIT},
        '{ROW_CFG, lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000, 5'd16, 1'b0, NO_HIT}
    };

    // Capacity of each random phase: mid values, the reset value, one, zero,
    // and values above the slot count that must saturate.
    localparam logic [lkv_pkg::CFG_W-1:0] PHASE_CAPACITY [NUM_PHASES] = '{
        5'd4, 5'd16, 5'd1, 5'd0, 5'd8, 5'd31, 5'd2, 5'd20, 5'd12, 5'd5
    };

    logic clk;
    logic rst_n;

    lkv_req_if req_ch ();
    lkv_rsp_if rsp_ch ();
    lkv_cfg_if cfg_ch ();

    lru_key_value_cache u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // Shadow state of the cache: one entry per slot with a recency rank,
    // rank 0 being the most recent.
    bit                             slot_valid [SLOTS];
    logic [lkv_pkg::KEY_PORT_W-1:0] slot_key   [SLOTS];
    logic [lkv_pkg::DATA_W-1:0]     slot_value [SLOTS];
    int unsigned                    slot_rank  [SLOTS];
    int unsigned                    fill_level;
    logic [lkv_pkg::CFG_W-1:0]      capacity_reg;

    t_outcome                       pending_responses [$];
    logic [lkv_pkg::KEY_PORT_W-1:0] key_pool [POOL_SIZE];
    int                             mismatch_count;
    int                             response_count;
    bit                             hold_request;

    // Clock: period of 12 time units.
    initial begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // Watchdog: far beyond the slowest legal run of the stimulus below.
    initial begin
        #7_200_000;
        $display("FAILURE");
        $finish;
    end

    // A zero capacity acts as one, and anything above the slot count saturates.
    function automatic int unsigned effective_capacity();
        if (capacity_reg == '0) begin
            return 1;
        end
        if (capacity_reg > SLOTS) begin
            return SLOTS;
        end
        return int'(capacity_reg);
    endfunction

    // Apply one get or put to the shadow state and return the response it causes.
    function automatic t_outcome lru_access(logic func, logic [lkv_pkg::KEY_PORT_W-1:0] key,
                                            logic [lkv_pkg::DATA_W-1:0] value);
        t_outcome    res;
        int          hit;
        int          slot;
        int unsigned oldest;
        int unsigned hit_rank;

        res  = NO_HIT;
        hit  = -1;
        slot = -1;
        oldest = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && slot_valid[i] && slot_key[i] == key) begin
                hit = i;
            end
        end

        if (hit >= 0) begin
            // Hit: report it, read or overwrite, then make the entry most recent.
            res.found = 1'b1;
            if (func == lkv_pkg::FUNC_GET) begin
                res.read_value = slot_value[hit];
            end else begin
                slot_value[hit] = value;
            end
            hit_rank = slot_rank[hit];
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_valid[i] && i != hit && slot_rank[i] < hit_rank) begin
                    slot_rank[i]++;
                end
            end
            slot_rank[hit] = 0;
        end else if (func == lkv_pkg::FUNC_PUT) begin
            // Miss on a put: when full (or over-full after the capacity was
            // lowered), drop the least recent entry and reuse its slot.
            if (fill_level >= effective_capacity()) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_valid[i] && (slot < 0 || slot_rank[i] > oldest)) begin
                        slot   = i;
                        oldest = slot_rank[i];
                    end
                end
                if (slot >= 0) begin
                    res.evicted     = 1'b1;
                    res.evicted_key = slot_key[slot];
                    slot_valid[slot] = 1'b0;
                    fill_level--;
                end
            end
            if (slot < 0) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot < 0 && !slot_valid[i]) begin
                        slot = i;
                    end
                end
            end
            if (slot >= 0) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_valid[i]) begin
                        slot_rank[i]++;
                    end
                end
                slot_valid[slot] = 1'b1;
                slot_key[slot]   = key;
                slot_value[slot] = value;
                slot_rank[slot]  = 0;
                fill_level++;
            end
        end
        return res;
    endfunction

    // Idle length between transfers: mostly none, some short, a few long.
    function automatic int pick_gap();
        int roll;

        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("mismatch in response %0d, %s: got %h, expected %h",
                 response_count, field, got, want);
    endtask

    // Offer one request after an optional gap and hold it until it transfers.
    // The expected response is computed at the transfer edge; a typed-in
    // outcome, where given, takes the place of the computed one.
    task automatic send_request(logic func, logic [lkv_pkg::KEY_PORT_W-1:0] key,
                                logic [lkv_pkg::DATA_W-1:0] value, logic typed,
                                t_outcome typed_outcome, int gap);
        t_outcome predicted;

        @(negedge clk);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.func  = func;
        req_ch.key   = key;
        req_ch.value = value;
        do @(posedge clk); while (!req_ch.ready);
        predicted = lru_access(func, key, value);
        pending_responses.push_back(typed ? typed_outcome : predicted);
    endtask

    // Wait for every outstanding response, let the chain settle its last
    // shift, then write the capacity register.
    task automatic write_capacity(logic [lkv_pkg::CFG_W-1:0] capacity);
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_responses.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = capacity;
        do @(posedge clk); while (!cfg_ch.ready);
        capacity_reg = capacity;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Response side: ready runs of random length broken by random gaps, and
    // one long hold-off on request, counted here in cycles, during which the
    // cache keeps its response waiting and must stall its request input.
    initial begin
        int ready_left;
        int idle_left;

        ready_left   = 0;
        idle_left    = 0;
        rsp_ch.ready = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                idle_left    = LONG_HOLD;
                ready_left   = 0;
            end
            if (idle_left > 0) begin
                rsp_ch.ready = 1'b0;
                idle_left--;
            end else begin
                rsp_ch.ready = 1'b1;
                if (ready_left > 0) begin
                    ready_left--;
                end else begin
                    ready_left = $urandom_range(0, 24);
                    idle_left  = pick_gap();
                end
            end
        end
    end

    // Response checker: every transfer is matched against the oldest expectation.
    always @(posedge clk) begin
        t_outcome want;

        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_responses.size() == 0) begin
                report_mismatch("unexpected response", rsp_ch.evicted_key, '0);
            end else begin
                want = pending_responses.pop_front();
                if (rsp_ch.found !== want.found) begin
                    report_mismatch("found", 32'(rsp_ch.found), 32'(want.found));
                end
                if (rsp_ch.read_value !== want.read_value) begin
                    report_mismatch("read_value", rsp_ch.read_value, want.read_value);
                end
                if (rsp_ch.evicted !== want.evicted) begin
                    report_mismatch("evicted", 32'(rsp_ch.evicted), 32'(want.evicted));
                end
                if (rsp_ch.evicted_key !== want.evicted_key) begin
                    report_mismatch("evicted_key", rsp_ch.evicted_key, want.evicted_key);
                end
            end
            response_count++;
        end
    end

    // Stimulus: reset, the directed table, then random phases, then drain.
    initial begin
        t_row                           row;
        bit                             no_gaps;
        int                             window;
        logic                           func;
        logic [lkv_pkg::KEY_PORT_W-1:0] key;

        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.func    = lkv_pkg::FUNC_GET;
        req_ch.key     = '0;
        req_ch.value   = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        hold_request   = 1'b0;
        mismatch_count = 0;
        response_count = 0;

        // The shadow state matches the cache after reset.
        for (int i = 0; i < SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_rank[i]  = 0;
        end
        fill_level   = 0;
        capacity_reg = lkv_pkg::CAP_RESET;

        // A pool of keys keeps the hit rate high; the all-zero and all-one
        // keys are always in it.
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < NUM_ROWS; r++) begin
            row = DIRECTED[r];
            if (row.kind == ROW_CFG) begin
                write_capacity(row.capacity);
            end else begin
                send_request(row.func, row.key, row.value, row.typed, row.outcome,
                             pick_gap());
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_capacity(PHASE_CAPACITY[p]);
            // Some phases run back to back; the second one also starts the
            // long hold-off on the response side.
            no_gaps = (p == 1) || ($urandom_range(0, 2) == 0);
            if (p == 1) begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Once, pause the requests until every response has come back.
                if (p == 4 && n == ITEMS_PER_PHASE / 2) begin
                    @(negedge clk);
                    req_ch.valid = 1'b0;
                    while (pending_responses.size() != 0) @(posedge clk);
                end
                window = 2 * effective_capacity() + 1;
                if (window > POOL_SIZE - 1) begin
                    window = POOL_SIZE - 1;
                end
                func = $urandom_range(0, 1) ? lkv_pkg::FUNC_PUT : lkv_pkg::FUNC_GET;
                if ($urandom_range(0, 7) == 0) begin
                    key = $urandom;
                end else begin
                    key = key_pool[$urandom_range(0, window)];
                end
                send_request(func, key, $urandom, 1'b0, NO_HIT, no_gaps ? 0 : pick_gap());
            end
        end

        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_responses.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/lkv_pkg.sv
hdl/lkv_if.sv
hdl/lkv_cell.sv
hdl/lru_key_value_cache.sv
test/testbench.sv
